### rtl/aes128_pkg.sv
// ----------------------------------------------------------------------------
// aes128_pkg
// Types, constants and round functions for the AES-128 CBC cipher core.
// ----------------------------------------------------------------------------
package aes128_pkg;

    typedef logic [7:0] byte_tab_t [256];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PRIME,
        ST_ROUND
    } state_t;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_HIGH    = 3'd0;
    localparam logic [2:0] REG_KEY_LOW     = 3'd1;
    localparam logic [2:0] REG_IV_HIGH     = 3'd2;
    localparam logic [2:0] REG_IV_LOW      = 3'd3;
    localparam logic [2:0] REG_DECRYPT     = 3'd4;

    localparam int          NUM_RKEYS  = 11;
    localparam logic [3:0]  LAST_ROUND = 4'd10;
    localparam logic [7:0]  RCON_FIRST = 8'h01;
    localparam logic [7:0]  POLY       = 8'h1b;

    localparam byte_tab_t SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // inverse table built at elaboration from the forward one
    function automatic byte_tab_t build_inv_sbox();
        byte_tab_t r;
        for (int i = 0; i < 256; i++) begin
            r[SBOX[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam byte_tab_t INV_SBOX = build_inv_sbox();

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? POLY : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i downwards
    function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = SBOX[get_b(s, i)];
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = INV_SBOX[get_b(s, i)];
        end
        return o;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8 * (4 * c + r) -: 8] = get_b(s, 4 * ((c + r) % 4) + r);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[127 - 8 * (4 * c + r) -: 8] = get_b(s, 4 * ((c - r + 4) % 4) + r);
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_b(s, 4 * c);
            a1 = get_b(s, 4 * c + 1);
            a2 = get_b(s, 4 * c + 2);
            a3 = get_b(s, 4 * c + 3);
            o[127 - 32 * c -: 32] = {
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end
        return o;
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_b(s, 4 * c);
            a1 = get_b(s, 4 * c + 1);
            a2 = get_b(s, 4 * c + 2);
            a3 = get_b(s, 4 * c + 3);
            o[127 - 32 * c -: 32] = {
                mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3),
                mul9(a0)  ^ mul14(a1) ^ mul11(a2) ^ mul13(a3),
                mul13(a0) ^ mul9(a1)  ^ mul14(a2) ^ mul11(a3),
                mul11(a0) ^ mul13(a1) ^ mul9(a2)  ^ mul14(a3)};
        end
        return o;
    endfunction

    // one step of the key schedule
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### rtl/aes128_cbc_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_core
// AES-128 block cipher in CBC mode with a round key memory.
// ----------------------------------------------------------------------------
// One 128-bit block is processed at a time. After a transaction is accepted, a
// prime step starts the round key memory read, then the round steps (initial key
// addition plus ten rounds) run through a single round unit fed from an
// 11 x 128-bit round key memory with a registered read, and the result is then
// ready in the output register. After reset, or after either key register is
// written, the first block also waits while the key schedule fills that memory. A
// new block is taken once the previous result has left the output register.
// Encryption chains on the previous ciphertext output, decryption on the previous
// ciphertext input; first_block reloads the chaining value from the IV registers.
module aes128_cbc_cipher_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // data_high [63:0], data_low [127:64]
    input  logic         s_tuser,   // first_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_high [63:0], result_low [127:64]
);

    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic         decrypt_reg;
    logic         stale_reg;
    aes128_pkg::state_t state_reg, state_next;
    logic [3:0]   cnt_reg;
    logic [127:0] kreg_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] s_reg;
    logic [127:0] xor_reg;
    logic [127:0] chain_reg;
    logic         mode_reg;
    logic [127:0] out_reg;
    logic         out_valid_reg;

    logic [127:0] rk_mem [aes128_pkg::NUM_RKEYS];
    logic [127:0] rk_rd;
    logic [3:0]   rd_addr;

    logic         accept;
    logic [127:0] in_blk;
    logic [127:0] chain_src;
    logic [127:0] round_out;
    logic [127:0] t_enc, t_dec;

    function automatic logic [127:0] shift_rows_w(input logic [127:0] s);
        return aes128_pkg::shift_rows(aes128_pkg::sub_bytes(s));
    endfunction

    assign accept    = s_tvalid & s_tready;
    assign in_blk    = {s_tdata[63:0], s_tdata[127:64]};
    assign chain_src = s_tuser ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_reg[63:0], out_reg[127:64]};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            decrypt_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aes128_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes128_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aes128_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                aes128_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_data;
                aes128_pkg::REG_DECRYPT:  decrypt_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aes128_pkg::ST_IDLE:
                if (accept)
                    state_next = stale_reg ? aes128_pkg::ST_EXPAND : aes128_pkg::ST_PRIME;
            aes128_pkg::ST_EXPAND:
                if (cnt_reg == aes128_pkg::LAST_ROUND)
                    state_next = aes128_pkg::ST_PRIME;
            aes128_pkg::ST_PRIME:
                state_next = aes128_pkg::ST_ROUND;
            aes128_pkg::ST_ROUND:
                if (cnt_reg == aes128_pkg::LAST_ROUND)
                    state_next = aes128_pkg::ST_IDLE;
            default:
                state_next = aes128_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            aes128_pkg::ST_IDLE:
                s_tready = !out_valid_reg;
            aes128_pkg::ST_EXPAND: ;
            aes128_pkg::ST_PRIME:
                rd_addr = mode_reg ? aes128_pkg::LAST_ROUND : 4'd0;
            aes128_pkg::ST_ROUND:
                if (cnt_reg != aes128_pkg::LAST_ROUND)
                    rd_addr = mode_reg ? aes128_pkg::LAST_ROUND - (cnt_reg + 4'd1)
                                       : cnt_reg + 4'd1;
            default: ;
        endcase
    end

    // round key memory
    always_ff @(posedge clk)
    begin
        if (state_reg == aes128_pkg::ST_EXPAND)
            rk_mem[cnt_reg] <= kreg_reg;
        rk_rd <= rk_mem[rd_addr];
    end

    // round unit
    always_comb
    begin
        t_enc = shift_rows_w(s_reg);
        t_dec = aes128_pkg::inv_sub_bytes(aes128_pkg::inv_shift_rows(s_reg)) ^ rk_rd;
        if (cnt_reg == 4'd0)
            round_out = s_reg ^ rk_rd;
        else if (!mode_reg)
            round_out = ((cnt_reg == aes128_pkg::LAST_ROUND) ? t_enc
                         : aes128_pkg::mix_columns(t_enc)) ^ rk_rd;
        else
            round_out = (cnt_reg == aes128_pkg::LAST_ROUND) ? t_dec
                        : aes128_pkg::inv_mix_columns(t_dec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aes128_pkg::ST_IDLE;
            stale_reg     <= 1'b1;
            cnt_reg       <= '0;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we && (cfg_index == aes128_pkg::REG_KEY_HIGH ||
                           cfg_index == aes128_pkg::REG_KEY_LOW))
                stale_reg <= 1'b1;

            unique case (state_reg)
                aes128_pkg::ST_IDLE:
                    if (accept)
                    begin
                        mode_reg <= decrypt_reg;
                        cnt_reg  <= '0;
                        if (decrypt_reg)
                            chain_reg <= in_blk;
                    end
                aes128_pkg::ST_EXPAND:
                    if (cnt_reg == aes128_pkg::LAST_ROUND)
                    begin
                        cnt_reg   <= '0;
                        stale_reg <= 1'b0;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                aes128_pkg::ST_PRIME: ;
                aes128_pkg::ST_ROUND:
                    if (cnt_reg == aes128_pkg::LAST_ROUND)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!mode_reg)
                            chain_reg <= round_out;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kreg_reg <= {key_high_reg, key_low_reg};
            rcon_reg <= aes128_pkg::RCON_FIRST;
            xor_reg  <= chain_src;
            s_reg    <= decrypt_reg ? in_blk : (in_blk ^ chain_src);
        end
        else if (state_reg == aes128_pkg::ST_EXPAND)
        begin
            kreg_reg <= aes128_pkg::key_step(kreg_reg, rcon_reg);
            rcon_reg <= aes128_pkg::xtime(rcon_reg);
        end
        else if (state_reg == aes128_pkg::ST_ROUND)
        begin
            s_reg <= round_out;
            if (cnt_reg == aes128_pkg::LAST_ROUND)
                out_reg <= mode_reg ? (round_out ^ xor_reg) : round_out;
        end
    end

endmodule
